### src/lpr_pkg.sv
`timescale 1ns / 1ps

package lpr_pkg;

    localparam int LPR_MAX_ROUTES = 64;
    localparam int LPR_NUM_PORTS  = 8;
    localparam int LPR_ADDR_W     = 32;
    localparam int LPR_LEN_W      = 6;
    localparam int LPR_PORT_W     = 3;
    localparam int LPR_TTL_W      = 8;
    localparam int LPR_STATUS_W   = 3;

    localparam logic [LPR_LEN_W-1:0]  LPR_FULL_LEN = LPR_LEN_W'(32);
    localparam logic [LPR_ADDR_W-1:0] LPR_ONES     = 32'hffff_ffff;

    localparam logic LPR_MODE_ADD   = 1'b0;
    localparam logic LPR_MODE_ROUTE = 1'b1;

    typedef enum logic [LPR_STATUS_W-1:0] {
        ST_FORWARDED   = 3'd0,
        ST_TTL_EXPIRED = 3'd1,
        ST_NO_ROUTE    = 3'd2,
        ST_STORED      = 3'd3,
        ST_FULL        = 3'd4
    } t_status;

    typedef struct packed {
        logic [LPR_ADDR_W-1:0] prefix;
        logic [LPR_LEN_W-1:0]  length;
        logic                  has_gw;
        logic [LPR_ADDR_W-1:0] gateway;
        logic [LPR_PORT_W-1:0] port;
    } t_entry;

endpackage

### src/lpr_ram.sv
`timescale 1ns / 1ps

module lpr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### src/ipv4_longest_prefix_router.sv
`timescale 1ns / 1ps

// channel  direction  handshake               payload
// in       input      i_in_valid / o_in_stall  i_mode i_address i_prefix_bits i_has_gateway
//                                             i_gateway i_port_index i_hop_limit
// out      output     o_out_valid / i_out_stall o_status o_out_port o_out_gateway
//                                             o_out_hop_limit
//
// one word at a time: an add or a lookup reads every stored route once through the
// single read port of the route ram, so its time from accept to result grows with the
// fill count; a datagram with expired ttl skips the scan, and the block returns to idle
// after it registers a result, before it takes the next word
// routes fill from slot 0 up and are never removed, so the fill count alone marks
// valid entries and reset only clears it, with no clearing pass
// o_in_stall is high while a word is in work; a stalled result holds the last cycle

module ipv4_longest_prefix_router #(
    parameter int MAX_ROUTES = lpr_pkg::LPR_MAX_ROUTES
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic                             i_mode,
    input  logic [lpr_pkg::LPR_ADDR_W-1:0]   i_address,
    input  logic [lpr_pkg::LPR_LEN_W-1:0]    i_prefix_bits,
    input  logic                             i_has_gateway,
    input  logic [lpr_pkg::LPR_ADDR_W-1:0]   i_gateway,
    input  logic [lpr_pkg::LPR_PORT_W-1:0]   i_port_index,
    input  logic [lpr_pkg::LPR_TTL_W-1:0]    i_hop_limit,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [lpr_pkg::LPR_STATUS_W-1:0] o_status,
    output logic [lpr_pkg::LPR_PORT_W-1:0]   o_out_port,
    output logic [lpr_pkg::LPR_ADDR_W-1:0]   o_out_gateway,
    output logic [lpr_pkg::LPR_TTL_W-1:0]    o_out_hop_limit
);

    import lpr_pkg::*;

    localparam int AW = $clog2(MAX_ROUTES);
    localparam int CW = $clog2(MAX_ROUTES + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(MAX_ROUTES);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } t_state;

    function automatic logic [LPR_ADDR_W-1:0] len_mask(input logic [LPR_LEN_W-1:0] len);
        len_mask = ~(LPR_ONES >> len);
    endfunction

    t_state r_state;
    logic [CW-1:0] r_count;
    logic [CW-1:0] r_rd_idx;
    logic          r_pend;
    logic [AW-1:0] r_pend_idx;

    // word under work
    logic                  r_mode;
    logic [LPR_ADDR_W-1:0] r_addr;
    logic [LPR_LEN_W-1:0]  r_len;
    logic                  r_has_gw;
    logic [LPR_ADDR_W-1:0] r_gw;
    logic [LPR_PORT_W-1:0] r_port;
    logic [LPR_TTL_W-1:0]  r_ttl;
    logic                  r_expired;

    // scan results
    logic                  r_hit;
    logic [AW-1:0]         r_hit_idx;
    logic [LPR_LEN_W-1:0]  r_best_len;
    logic                  r_best_has_gw;
    logic [LPR_ADDR_W-1:0] r_best_gw;
    logic [LPR_PORT_W-1:0] r_best_port;

    logic                    r_out_valid;
    logic [LPR_STATUS_W-1:0] r_status;
    logic [LPR_PORT_W-1:0]   r_out_port;
    logic [LPR_ADDR_W-1:0]   r_out_gw;
    logic [LPR_TTL_W-1:0]    r_out_ttl;

    t_entry        rd_entry;
    t_entry        wr_entry;
    logic [LPR_ADDR_W-1:0] rd_data;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic          issue;
    logic          in_acc;
    logic          out_free;
    logic          add_match;
    logic          route_match;
    logic          better;
    logic          is_full;
    logic [LPR_LEN_W-1:0] in_len;

    assign in_acc   = i_in_valid && (r_state == S_IDLE);
    assign out_free = !r_out_valid || !i_out_stall;
    assign issue    = (r_state == S_SCAN) && (r_rd_idx < r_count);
    assign in_len   = (i_prefix_bits > LPR_FULL_LEN) ? LPR_FULL_LEN : i_prefix_bits;

    assign add_match   = (rd_entry.prefix == r_addr) && (rd_entry.length == r_len);
    assign route_match = (r_addr & len_mask(rd_entry.length)) == rd_entry.prefix;
    assign better      = !r_hit || (rd_entry.length > r_best_len);
    assign is_full     = !r_hit && (r_count == FULL_COUNT);

    assign wr_entry.prefix  = r_addr;
    assign wr_entry.length  = r_len;
    assign wr_entry.has_gw  = r_has_gw;
    assign wr_entry.gateway = r_gw;
    assign wr_entry.port    = r_port;

    assign ram_we    = (r_state == S_FINISH) && out_free && (r_mode == LPR_MODE_ADD) && !is_full;
    assign ram_waddr = r_hit ? r_hit_idx : r_count[AW-1:0];

    lpr_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (MAX_ROUTES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (wr_entry),
        .i_raddr (r_rd_idx[AW-1:0]),
        .o_rdata (rd_entry)
    );

    // next hop, the destination itself for a direct route
    assign rd_data = r_best_has_gw ? r_best_gw : r_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_rd_idx    <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
            r_hit       <= 1'b0;
        end else begin
            // in finish a taken result is replaced by the new one below
            if (r_out_valid && !i_out_stall && (r_state != S_FINISH)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_mode    <= i_mode;
                        r_addr    <= (i_mode == LPR_MODE_ADD) ? (i_address & len_mask(in_len))
                                                              : i_address;
                        r_len     <= in_len;
                        r_has_gw  <= i_has_gateway;
                        r_gw      <= i_gateway;
                        r_port    <= i_port_index;
                        r_ttl     <= i_hop_limit;
                        r_expired <= (i_mode == LPR_MODE_ROUTE) && (i_hop_limit <= 8'd1);
                        r_hit     <= 1'b0;
                        r_rd_idx  <= '0;
                        r_pend    <= 1'b0;
                        r_state   <= ((i_mode == LPR_MODE_ROUTE) && (i_hop_limit <= 8'd1))
                                     ? S_FINISH : S_SCAN;
                    end
                end
                S_SCAN: begin
                    r_pend     <= issue;
                    r_pend_idx <= r_rd_idx[AW-1:0];
                    if (issue) begin
                        r_rd_idx <= r_rd_idx + CW'(1);
                    end
                    if (r_pend) begin
                        if (r_mode == LPR_MODE_ADD) begin
                            // first equal entry is the one to replace
                            if (!r_hit && add_match) begin
                                r_hit     <= 1'b1;
                                r_hit_idx <= r_pend_idx;
                            end
                        end else if (route_match && better) begin
                            r_hit         <= 1'b1;
                            r_best_len    <= rd_entry.length;
                            r_best_has_gw <= rd_entry.has_gw;
                            r_best_gw     <= rd_entry.gateway;
                            r_best_port   <= rd_entry.port;
                        end
                    end
                    if (!issue && !r_pend) begin
                        r_state <= S_FINISH;
                    end
                end
                S_FINISH: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_port  <= '0;
                        r_out_gw    <= '0;
                        r_out_ttl   <= '0;
                        if (r_mode == LPR_MODE_ADD) begin
                            r_status <= is_full ? ST_FULL : ST_STORED;
                            if (!is_full && !r_hit) begin
                                r_count <= r_count + CW'(1);
                            end
                        end else if (r_expired) begin
                            r_status <= ST_TTL_EXPIRED;
                        end else if (!r_hit || (int'(r_best_port) >= LPR_NUM_PORTS)) begin
                            r_status <= ST_NO_ROUTE;
                        end else begin
                            r_status   <= ST_FORWARDED;
                            r_out_port <= r_best_port;
                            r_out_gw   <= rd_data;
                            r_out_ttl  <= r_ttl - 8'd1;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall      = (r_state != S_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_status        = r_status;
    assign o_out_port      = r_out_port;
    assign o_out_gateway   = r_out_gw;
    assign o_out_hop_limit = r_out_ttl;

endmodule
